// ===== hdl/fifo_queue_with_search_defines.svh =====
// Assertion macros used by the port-level checker of the search queue.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsq check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsq check failed");

`endif

// ===== hdl/fsq_pkg.sv =====
// Types and constants of the FIFO queue with search.
package fsq_pkg;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int FILL_W   = 7;
	localparam int CFG_W    = 7;
	localparam int S_DATA_W = 32;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 56;

	localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

	localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_SHIFT,
		CELL_ROTATE
	} fsq_cell_op_t;

	typedef struct packed {
		fsq_cell_op_t         op;
		logic [VALUE_W-1:0]   wdata;
	} fsq_cell_ctl_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_EXEC,
		FS_SCAN,
		FS_REPORT
	} fsq_state_t;

endpackage

// ===== hdl/fifo_queue_with_search.sv =====
// Top level of the FIFO queue with search: controller and chain of storage cells.
//
// A FIFO of 32-bit entries built as a row of cells, cell 0 always holding the
// head. Commands arrive on s_tuser with the value on s_tdata; each yields one
// result on m_tdata. Enqueue, dequeue, peek, clear and unused codes stream at
// one per cycle while results are taken; the command is registered first, and
// its result is then registered into m_tdata. A search on n stored entries
// rotates the occupied cells of the chain one place per cycle past the
// comparator at cell 0, and a full turn restores the order; an empty queue is
// reported as not found without rotating. A capacity write on the cfg channel
// empties the queue and takes effect at once.
module fifo_queue_with_search #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsq_pkg::CFG_W-1:0]     cfg_data,     // capacity_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fsq_pkg::S_DATA_W-1:0]  s_tdata,      // [31:0] value
	input  logic [fsq_pkg::S_USER_W-1:0]  s_tuser,      // [2:0] cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] status, [33:2] data_out, [39:34] found_slot, [46:40] fill_count,
	// [47] is_empty, [48] is_full, [55:49] zero
	output logic [fsq_pkg::M_DATA_W-1:0]  m_tdata
);
	import fsq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	fsq_cell_ctl_t       cell_ctl;
	logic [CW-1:0]       cell_sel;
	logic [VALUE_W-1:0]  cell_data [DEPTH];
	logic [VALUE_W-1:0]  cell_next [DEPTH];

	fsq_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.head_data (cell_data[0]),
		.cell_ctl  (cell_ctl),
		.cell_sel  (cell_sel)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_end
			assign cell_next[i] = '0;
		end else begin : g_mid
			assign cell_next[i] = cell_data[i+1];
		end

		fsq_cell #(
			.IDX   (i),
			.SEL_W (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.sel        (cell_sel),
			.next_data  (cell_next[i]),
			.first_data (cell_data[0]),
			.data       (cell_data[i])
		);
	end

endmodule

// ===== hdl/fsq_cell.sv =====
// One storage cell of the queue chain: holds one entry, takes from its neighbor.
module fsq_cell #(
	parameter int IDX   = 0,
	parameter int SEL_W = 7
) (
	input  logic                          clk,
	input  fsq_pkg::fsq_cell_ctl_t        ctl,
	input  logic [SEL_W-1:0]              sel,
	input  logic [fsq_pkg::VALUE_W-1:0]   next_data,
	input  logic [fsq_pkg::VALUE_W-1:0]   first_data,
	output logic [fsq_pkg::VALUE_W-1:0]   data
);
	import fsq_pkg::*;

	logic [VALUE_W-1:0] data_q;
	logic               sel_eq;
	logic               sel_gt;

	assign sel_eq = (sel == SEL_W'(IDX));
	assign sel_gt = (sel > SEL_W'(IDX));
	assign data   = data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_WRITE: begin
				if (sel_eq) data_q <= ctl.wdata;
			end
			CELL_SHIFT: begin
				data_q <= next_data;
			end
			CELL_ROTATE: begin
				// last occupied cell wraps the head entry around
				if (sel_eq) data_q <= first_data;
				else if (sel_gt) data_q <= next_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// ===== hdl/fsq_ctrl.sv =====
// Queue controller: handshakes, head and count, search sequencing, result register.
module fsq_ctrl #(
	parameter int DEPTH = 64,
	parameter int CW    = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fsq_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [fsq_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fsq_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic [fsq_pkg::VALUE_W-1:0]   head_data,
	output fsq_pkg::fsq_cell_ctl_t        cell_ctl,
	output logic [CW-1:0]                 cell_sel
);
	import fsq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fsq_state_t           state_q, state_d;
	logic [CFG_W-1:0]     cap_q;
	logic [CW-1:0]        eff_cap;
	logic [CW-1:0]        count_q, count_d;
	logic [IDX_W-1:0]     head_q, head_d;
	logic [CMD_W-1:0]     cmd_s1;
	logic [VALUE_W-1:0]   value_s1;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        fk_q;
	logic                 found_q;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;

	logic                 out_free;
	logic                 accept;
	logic                 finish;
	logic                 start_scan;
	logic                 scan_last;
	logic [CW-1:0]        head_inc;
	logic [IDX_W-1:0]     head_adv;
	logic [CW:0]          slot_sum;
	logic [CW:0]          slot_wrap;
	logic [STATUS_W-1:0]  res_status;
	logic [VALUE_W-1:0]   res_data;
	logic [SLOT_W-1:0]    res_slot;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	// saturate capacity to 1..DEPTH
	always_comb begin
		eff_cap = CW'(cap_q);
		if (cap_q == '0) eff_cap = CW'(1);
		else if (CW'(cap_q) > CW'(DEPTH)) eff_cap = CW'(DEPTH);
	end

	assign head_inc  = CW'(head_q) + CW'(1);
	assign head_adv  = (head_inc >= eff_cap) ? '0 : IDX_W'(head_inc);
	assign slot_sum  = {1'b0, CW'(head_q)} + {1'b0, fk_q};
	assign slot_wrap = (slot_sum >= {1'b0, eff_cap}) ? (slot_sum - {1'b0, eff_cap}) : slot_sum;
	assign scan_last = (k_q == (count_q - CW'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (accept) state_d = FS_EXEC;
			end
			FS_EXEC: begin
				if (start_scan) state_d = FS_SCAN;
				else if (out_free) state_d = accept ? FS_EXEC : FS_IDLE;
			end
			FS_SCAN: begin
				if (scan_last) state_d = FS_REPORT;
			end
			FS_REPORT: begin
				if (out_free) state_d = accept ? FS_EXEC : FS_IDLE;
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		start_scan     = 1'b0;
		finish         = 1'b0;
		cell_ctl.op    = CELL_HOLD;
		cell_ctl.wdata = value_s1;
		cell_sel       = count_q;
		case (state_q)
			FS_IDLE: begin
				finish = 1'b0;
			end
			FS_EXEC: begin
				start_scan = (cmd_s1 == CMD_SEARCH) && (count_q != '0);
				finish     = out_free && !start_scan;
				if (finish && (cmd_s1 == CMD_ENQ) && (count_q < eff_cap))
					cell_ctl.op = CELL_WRITE;
				if (finish && (cmd_s1 == CMD_DEQ) && (count_q != '0))
					cell_ctl.op = CELL_SHIFT;
			end
			FS_SCAN: begin
				cell_ctl.op = CELL_ROTATE;
				cell_sel    = count_q - CW'(1);
			end
			FS_REPORT: begin
				finish = out_free;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == FS_IDLE) || finish;

	// result and state update of the command that finishes
	always_comb begin
		res_status = ST_OK;
		res_data   = '0;
		res_slot   = '0;
		count_d    = count_q;
		head_d     = head_q;
		if (state_q == FS_REPORT) begin
			if (found_q) res_slot = slot_wrap[SLOT_W-1:0];
			else res_status = ST_NOTFOUND;
		end else begin
			case (cmd_s1)
				CMD_ENQ: begin
					if (count_q >= eff_cap) res_status = ST_FULL;
					else count_d = count_q + CW'(1);
				end
				CMD_DEQ: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = head_data;
						head_d   = head_adv;
						count_d  = count_q - CW'(1);
					end
				end
				CMD_PEEK: begin
					if (count_q == '0) res_status = ST_EMPTY;
					else res_data = head_data;
				end
				CMD_SEARCH: begin
					res_status = ST_NOTFOUND;
				end
				CMD_CLEAR: begin
					count_d = '0;
					head_d  = '0;
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FS_IDLE;
			cap_q      <= CAP_RESET;
			count_q    <= '0;
			head_q     <= '0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			k_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cap_q   <= cfg_data;
				count_q <= '0;
				head_q  <= '0;
			end else if (finish) begin
				count_q <= count_d;
				head_q  <= head_d;
			end
			if (finish) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (start_scan) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end else if (state_q == FS_SCAN) begin
				k_q <= k_q + CW'(1);
				if (!found_q && (head_data == value_s1)) found_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_tuser;
			value_s1 <= s_tdata;
		end
		if ((state_q == FS_SCAN) && !found_q && (head_data == value_s1)) fk_q <= k_q;
		if (finish) begin
			m_tdata_q <= {7'd0,
				(count_d == eff_cap),
				(count_d == '0),
				count_d[FILL_W-1:0],
				res_slot,
				res_data,
				res_status};
		end
	end

endmodule

// ===== hdl/fsq_checker.sv =====
// Port-level checks of the FIFO queue with search, bound to the top level.
`include "fifo_queue_with_search_defines.svh"

module fsq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fsq_pkg::M_DATA_W-1:0]  m_tdata
);
	import fsq_pkg::*;

	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  data_out;
	logic [FILL_W-1:0]   fill_count;
	logic                is_empty;
	logic                is_full;

	assign status     = m_tdata[1:0];
	assign data_out   = m_tdata[33:2];
	assign fill_count = m_tdata[46:40];
	assign is_empty   = m_tdata[47];
	assign is_full    = m_tdata[48];

	`FSQ_ASSERT_NEXT(a_hold_result, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`FSQ_ASSERT_NOW(a_empty_flag, clk, arst_n, m_tvalid, is_empty == (fill_count == '0))
	`FSQ_ASSERT_NOW(a_not_both, clk, arst_n, m_tvalid, !(is_empty && is_full))
	`FSQ_ASSERT_NOW(a_refused_full, clk, arst_n, m_tvalid && (status == ST_FULL), is_full && (data_out == '0))
	`FSQ_ASSERT_NOW(a_refused_empty, clk, arst_n, m_tvalid && (status == ST_EMPTY), is_empty && (data_out == '0))

endmodule

bind fifo_queue_with_search fsq_checker u_fsq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
